// ===== rtl/length_prefixed_frame_deframer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the length-prefixed frame deframer
// Shared property shapes for the port checker.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LPFD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpfd: same-cycle property failed");

// next-cycle implication, disabled in reset
`define LPFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpfd: next-cycle property failed");

`endif

// ===== rtl/lpfd_pkg.sv =====
// ---------------------------------------------------------------------------
// lpfd_pkg
// Widths, header layout, result codes and register map of the deframer.
// ---------------------------------------------------------------------------
package lpfd_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int OPCODE_W = 16;
   localparam int VER_W    = 16;
   localparam int WORD_W   = 32;
   localparam int LEN_W    = 21;
   localparam int KIND_W   = 2;
   localparam int ERR_W    = 2;

   // header layout, little-endian
   localparam int HDR_BYTES = 16;
   localparam int HDR_POS_W = $clog2(HDR_BYTES);
   localparam logic [HDR_POS_W-1:0] POS_VERSION = HDR_POS_W'(4);
   localparam logic [HDR_POS_W-1:0] POS_OPCODE  = HDR_POS_W'(6);
   localparam logic [HDR_POS_W-1:0] POS_LENGTH  = HDR_POS_W'(8);
   localparam logic [HDR_POS_W-1:0] POS_REQUEST = HDR_POS_W'(12);
   localparam logic [HDR_POS_W-1:0] POS_LAST    = HDR_POS_W'(HDR_BYTES - 1);

   // length limits
   localparam logic [LEN_W-1:0] LEN_MAX           = {LEN_W{1'b1}};
   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(1024 * 1024);

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   // error codes
   typedef enum logic [ERR_W-1:0] {
      ERR_MAGIC   = 2'd0,
      ERR_VERSION = 2'd1,
      ERR_LENGTH  = 2'd2
   } err_type;

   // register map
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   typedef enum logic [1:0] {
      REG_MAGIC   = 2'd0,
      REG_VERSION = 2'd1,
      REG_MAX_LEN = 2'd2
   } reg_idx_type;

   // configuration seen by the core
   typedef struct packed {
      logic [WORD_W-1:0] magic;
      logic [VER_W-1:0]  version;
      logic [LEN_W-1:0]  max_len;
   } cfg_type;

endpackage

// ===== rtl/lpfd_req_if.sv =====
// ---------------------------------------------------------------------------
// lpfd_req_if
// Byte stream channel into the deframer.
// ---------------------------------------------------------------------------
interface lpfd_req_if import lpfd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/lpfd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// lpfd_rsp_if
// Result channel: header, payload byte or error words.
// ---------------------------------------------------------------------------
interface lpfd_rsp_if import lpfd_pkg::*;;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   out_kind;
   logic [OPCODE_W-1:0] msg_opcode;
   logic [WORD_W-1:0]   request_tag;
   logic [LEN_W-1:0]    payload_length;
   logic [BYTE_W-1:0]   payload_byte;
   logic                last_of_message;
   logic [ERR_W-1:0]    error_kind;

   modport source (output valid, output out_kind, output msg_opcode,
                   output request_tag, output payload_length, output payload_byte,
                   output last_of_message, output error_kind, input ready);
   modport sink   (input valid, input out_kind, input msg_opcode,
                   input request_tag, input payload_length, input payload_byte,
                   input last_of_message, input error_kind, output ready);
endinterface

// ===== rtl/lpfd_csr.sv =====
// ---------------------------------------------------------------------------
// lpfd_csr
// APB-style register bank: expected magic, expected version, length limit.
// ---------------------------------------------------------------------------
module lpfd_csr import lpfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [WORD_W-1:0] magic_ff,   magic_in;
   logic [VER_W-1:0]  version_ff, version_in;
   logic [LEN_W-1:0]  max_len_ff, max_len_in;
   logic              wr_en;
   reg_idx_type       idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);

   // write decode; the unmapped word is ignored
   always_comb begin
      magic_in   = magic_ff;
      version_in = version_ff;
      max_len_in = max_len_ff;
      if (wr_en) begin
         unique case (idx)
            REG_MAGIC:   magic_in   = pwdata;
            REG_VERSION: version_in = pwdata[VER_W-1:0];
            REG_MAX_LEN: max_len_in = pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_MAGIC:   prdata = magic_ff;
         REG_VERSION: prdata = CSR_DATA_W'(version_ff);
         REG_MAX_LEN: prdata = CSR_DATA_W'(max_len_ff);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= '0;
         version_ff <= '0;
         max_len_ff <= MAX_PAYLOAD_RESET;
      end else begin
         magic_ff   <= magic_in;
         version_ff <= version_in;
         max_len_ff <= max_len_in;
      end
   end

   assign cfg.magic   = magic_ff;
   assign cfg.version = version_ff;
   assign cfg.max_len = max_len_ff;

endmodule

// ===== rtl/lpfd_core.sv =====
// ---------------------------------------------------------------------------
// lpfd_core
// Input byte register, header/payload sequencer and result register.
// ---------------------------------------------------------------------------
module lpfd_core import lpfd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   lpfd_req_if.sink   req_ch,
   lpfd_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_ERROR   = 2'd2
   } phase_type;

   // control state
   logic                 in_valid_ff,  in_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   phase_type            phase_ff,     phase_in;
   logic [HDR_POS_W-1:0] pos_ff,       pos_in;

   // data state
   logic [BYTE_W-1:0]    in_byte_ff,   in_byte_in;
   logic [WORD_W-1:0]    magic_ff,     magic_in;
   logic [VER_W-1:0]     version_ff,   version_in;
   logic [OPCODE_W-1:0]  opcode_ff,    opcode_in;
   logic [WORD_W-1:0]    length_ff,    length_in;
   logic [WORD_W-1:0]    request_ff,   request_in;
   logic [LEN_W-1:0]     remain_ff,    remain_in;

   // result register
   kind_type             rsp_kind_ff,   rsp_kind_in;
   logic [OPCODE_W-1:0]  rsp_opcode_ff, rsp_opcode_in;
   logic [WORD_W-1:0]    rsp_tag_ff,    rsp_tag_in;
   logic [LEN_W-1:0]     rsp_len_ff,    rsp_len_in;
   logic [BYTE_W-1:0]    rsp_byte_ff,   rsp_byte_in;
   logic                 rsp_last_ff,   rsp_last_in;
   err_type              rsp_err_ff,    rsp_err_in;

   logic                 out_free;
   logic                 fire;
   logic                 accept;
   logic [LEN_W-1:0]     len_sat;
   logic [LEN_W-1:0]     len_low;
   logic                 len_over;

   // the held byte moves on when the result slot is free or draining
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   // announced length, clipped and compared against the limit
   assign len_low  = length_ff[LEN_W-1:0];
   assign len_over = |length_ff[WORD_W-1:LEN_W];
   assign len_sat  = len_over ? LEN_MAX : len_low;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      rsp_valid_in  = rsp_valid_ff;
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      magic_in      = magic_ff;
      version_in    = version_ff;
      opcode_in     = opcode_ff;
      length_in     = length_ff;
      request_in    = request_ff;
      remain_in     = remain_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_opcode_in = rsp_opcode_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_err_in    = rsp_err_ff;

      // input register
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_ch.data_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      // result drains on handshake
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (fire) begin
         unique case (phase_ff)
            // stream one payload byte
            PH_PAYLOAD: begin
               remain_in     = remain_ff - LEN_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_PAYLOAD;
               rsp_opcode_in = opcode_ff;
               rsp_tag_in    = request_ff;
               rsp_len_in    = len_low;
               rsp_byte_in   = in_byte_ff;
               rsp_last_in   = (remain_ff == LEN_W'(1));
               rsp_err_in    = ERR_MAGIC;
               if (remain_ff == LEN_W'(1)) begin
                  phase_in = PH_HEADER;
               end
            end
            // shift the byte into its header field
            PH_HEADER: begin
               priority if (pos_ff < POS_VERSION) begin
                  magic_in = {in_byte_ff, magic_ff[WORD_W-1:BYTE_W]};
               end else if (pos_ff < POS_OPCODE) begin
                  version_in = {in_byte_ff, version_ff[VER_W-1:BYTE_W]};
               end else if (pos_ff < POS_LENGTH) begin
                  opcode_in = {in_byte_ff, opcode_ff[OPCODE_W-1:BYTE_W]};
               end else if (pos_ff < POS_REQUEST) begin
                  length_in = {in_byte_ff, length_ff[WORD_W-1:BYTE_W]};
               end else begin
                  request_in = {in_byte_ff, request_ff[WORD_W-1:BYTE_W]};
               end

               if (pos_ff == POS_LAST) begin
                  // header complete: checks in order magic, version, length
                  pos_in        = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_opcode_in = opcode_ff;
                  rsp_tag_in    = request_in;
                  rsp_byte_in   = '0;
                  priority if (magic_ff != cfg.magic) begin
                     phase_in    = PH_ERROR;
                     rsp_kind_in = KIND_ERROR;
                     rsp_len_in  = len_sat;
                     rsp_last_in = 1'b1;
                     rsp_err_in  = ERR_MAGIC;
                  end else if (version_ff != cfg.version) begin
                     phase_in    = PH_ERROR;
                     rsp_kind_in = KIND_ERROR;
                     rsp_len_in  = len_sat;
                     rsp_last_in = 1'b1;
                     rsp_err_in  = ERR_VERSION;
                  end else if (len_over || (len_low > cfg.max_len)) begin
                     phase_in    = PH_ERROR;
                     rsp_kind_in = KIND_ERROR;
                     rsp_len_in  = len_sat;
                     rsp_last_in = 1'b1;
                     rsp_err_in  = ERR_LENGTH;
                  end else begin
                     remain_in   = len_low;
                     rsp_kind_in = KIND_HEADER;
                     rsp_len_in  = len_low;
                     rsp_last_in = (len_low == '0);
                     rsp_err_in  = ERR_MAGIC;
                     phase_in    = (len_low == '0) ? PH_HEADER : PH_PAYLOAD;
                  end
               end else begin
                  pos_in = pos_ff + HDR_POS_W'(1);
               end
            end
            // error phase: bytes are dropped until reset
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
      end
      in_byte_ff    <= in_byte_in;
      magic_ff      <= magic_in;
      version_ff    <= version_in;
      opcode_ff     <= opcode_in;
      length_ff     <= length_in;
      request_ff    <= request_in;
      remain_ff     <= remain_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_opcode_ff <= rsp_opcode_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_err_ff    <= rsp_err_in;
   end

   // result port
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.out_kind        = rsp_kind_ff;
   assign rsp_ch.msg_opcode      = rsp_opcode_ff;
   assign rsp_ch.request_tag     = rsp_tag_ff;
   assign rsp_ch.payload_length  = rsp_len_ff;
   assign rsp_ch.payload_byte    = rsp_byte_ff;
   assign rsp_ch.last_of_message = rsp_last_ff;
   assign rsp_ch.error_kind      = rsp_err_ff;

endmodule

// ===== rtl/length_prefixed_frame_deframer.sv =====
// Path: a byte taken in is held in the input byte register and decoded into the result register.
// Throughput: one byte per cycle while the result port is not stalled; the single pass from the input byte register
// through the header/payload decode to the result register sets that figure.
// A stalled result holds the decode; one more byte can still be taken in.
// Reset (synchronous) returns to the header phase, empties both registers and
// restores the register defaults; an error phase is left only by reset.
// ---------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Deframes a byte stream into header, payload byte and error words.
// ---------------------------------------------------------------------------
module length_prefixed_frame_deframer import lpfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lpfd_req_if.sink              req_ch,
   lpfd_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;

   // register bank
   lpfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // deframing datapath
   lpfd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== rtl/lpfd_checker.sv =====
// ---------------------------------------------------------------------------
// lpfd_checker
// Port-level checks on the deframer result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_assert.svh"

module lpfd_checker import lpfd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [KIND_W-1:0] rsp_out_kind,
   input logic [BYTE_W-1:0] rsp_payload_byte,
   input logic              rsp_last,
   input logic [ERR_W-1:0]  rsp_error_kind
);

   logic err_seen_ff, err_seen_in;

   // remembers that an error word has been delivered
   assign err_seen_in = err_seen_ff ||
                        (rsp_valid && rsp_ready && (rsp_out_kind == KIND_ERROR));

   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else begin
         err_seen_ff <= err_seen_in;
      end
   end

   // a stalled result keeps its word
   `LPFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_kind) && $stable(rsp_payload_byte))

   // an error always closes its message
   `LPFD_ASSERT_IMPL(a_err_last, clock, reset,
      rsp_valid && (rsp_out_kind == KIND_ERROR), rsp_last)

   // nothing comes out once an error has gone
   `LPFD_ASSERT_IMPL(a_silent_after_err, clock, reset, err_seen_ff, !rsp_valid)

   // the payload byte and the error code read zero in words of other kinds
   `LPFD_ASSERT_IMPL(a_unused_zero, clock, reset, rsp_valid,
      ((rsp_out_kind == KIND_PAYLOAD) || (rsp_payload_byte == '0)) &&
      ((rsp_out_kind == KIND_ERROR) || (rsp_error_kind == '0)))

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_out_kind     (rsp_ch.out_kind),
   .rsp_payload_byte (rsp_ch.payload_byte),
   .rsp_last         (rsp_ch.last_of_message),
   .rsp_error_kind   (rsp_ch.error_kind)
);
